FILE: hdl/psfr_pkg.sv
// Shared types and constants for the particle sensor frame receiver.
// No dependencies; used by every module of the block.
package psfr_pkg;

    localparam int POS_W   = 6;
    localparam int Q_DEPTH = 2;
    localparam int RESP_LAST = 8;

    localparam logic [7:0] HDR_ACTIVE_0 = 8'h42;
    localparam logic [7:0] HDR_ACTIVE_1 = 8'h4D;
    localparam logic [7:0] HDR_RESPONSE = 8'hFF;
    localparam logic [7:0] CMD_QUERY    = 8'h86;

    typedef enum logic [0:0] {
        OP_RX  = 1'b0,
        OP_CMD = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_ACTIVE_OK = 3'd0,
        ST_RESP_OK   = 3'd1,
        ST_HDR_BAD   = 3'd2,
        ST_LEN_BAD   = 3'd3,
        ST_SUM_BAD   = 3'd4
    } t_status;

    typedef struct packed {
        t_status     status;
        logic        show_pm;
        logic [15:0] pm_1_0;
        logic [15:0] pm_2_5;
        logic [15:0] pm_10_0;
    } t_token;

endpackage

FILE: hdl/psfr_front.sv
// Front end: accepts transactions, tracks frame position and checksum, classifies frames.
// Depends on psfr_pkg; pushes result tokens into psfr_queue.
module psfr_front #(
    parameter int FRAME_BYTES = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  psfr_pkg::t_op        i_op,
    input  logic [7:0]           i_byte,
    input  logic                 i_gap,
    input  logic                 i_full,
    output logic                 o_push,
    output psfr_pkg::t_token     o_tok
);

    localparam int PW = psfr_pkg::POS_W;
    localparam logic [PW-1:0] LAST     = PW'(FRAME_BYTES - 1);
    localparam logic [PW-1:0] RLAST    = PW'(psfr_pkg::RESP_LAST);
    localparam logic [15:0]   LEN_WORD = 16'(FRAME_BYTES - 4);

    logic [PW-1:0] r_pos, n_pos;
    logic [15:0]   r_sum, n_sum;
    logic          r_mode, n_mode;
    logic [7:0]    r_hold [1:7];
    logic [7:0]    r_prev;

    logic          accept;
    logic          rx;
    logic [PW-1:0] pos;
    logic [15:0]   sum;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign rx      = accept && (i_op == psfr_pkg::OP_RX);
    assign pos     = i_gap ? '0 : r_pos;
    assign sum     = i_gap ? '0 : r_sum;

    always_comb begin
        n_pos  = r_pos;
        n_sum  = r_sum;
        n_mode = r_mode;
        o_push = 1'b0;
        o_tok.status  = psfr_pkg::ST_HDR_BAD;
        o_tok.show_pm = (r_hold[1] == psfr_pkg::CMD_QUERY);
        o_tok.pm_1_0  = {r_hold[6], r_hold[7]};
        o_tok.pm_2_5  = {r_hold[2], r_hold[3]};
        o_tok.pm_10_0 = {r_hold[4], r_hold[5]};
        if (accept && i_op == psfr_pkg::OP_CMD) begin
            n_pos  = '0;
            n_sum  = '0;
            n_mode = (i_byte == psfr_pkg::CMD_QUERY);
        end else if (rx) begin
            o_push = 1'b1;
            n_pos  = '0;
            n_sum  = '0;
            if (r_mode) begin
                if (pos == '0 && i_byte != psfr_pkg::HDR_RESPONSE) begin
                    o_tok.status = psfr_pkg::ST_HDR_BAD;
                end else if (pos >= RLAST) begin
                    if (i_byte != 8'(8'hFF - sum[7:0])) begin
                        o_tok.status = psfr_pkg::ST_SUM_BAD;
                    end else begin
                        o_tok.status = psfr_pkg::ST_RESP_OK;
                        n_mode       = 1'b0;
                    end
                end else begin
                    o_push = 1'b0;
                end
            end else begin
                if ((pos == PW'(0) && i_byte != psfr_pkg::HDR_ACTIVE_0) ||
                    (pos == PW'(1) && i_byte != psfr_pkg::HDR_ACTIVE_1)) begin
                    o_tok.status = psfr_pkg::ST_HDR_BAD;
                end else if (pos == PW'(3) && {r_hold[2], i_byte} != LEN_WORD) begin
                    o_tok.status = psfr_pkg::ST_LEN_BAD;
                end else if (pos >= LAST) begin
                    o_tok.status = ({r_prev, i_byte} != sum) ?
                                   psfr_pkg::ST_SUM_BAD : psfr_pkg::ST_ACTIVE_OK;
                end else begin
                    o_push = 1'b0;
                end
            end
            if (!o_push) begin
                n_pos = pos + PW'(1);
                n_sum = (pos < LAST - PW'(1)) ? sum + 16'(i_byte) : sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_sum  <= '0;
            r_mode <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_sum  <= n_sum;
            r_mode <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx) begin
            r_prev <= i_byte;
            for (int i = 1; i <= 7; i++) begin
                if (pos == PW'(i)) begin
                    r_hold[i] <= i_byte;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LAST) else $error("frame position past last byte");
    a_resp_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode |-> r_pos <= RLAST) else $error("response frame position overrun");
    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full) else $error("push into full queue");
    a_cmd_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_op == psfr_pkg::OP_CMD) |=> (r_pos == '0 && r_sum == '0))
        else $error("command did not restart frame");
`endif

endmodule

FILE: hdl/psfr_queue.sv
// Short result token queue between the front end and the output stage.
// Depends on psfr_pkg for the token type and depth.
module psfr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  psfr_pkg::t_token i_tok,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output psfr_pkg::t_token o_tok
);

    localparam int AW = $clog2(psfr_pkg::Q_DEPTH);
    localparam int CW = $clog2(psfr_pkg::Q_DEPTH + 1);

    psfr_pkg::t_token r_mem [psfr_pkg::Q_DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(psfr_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == AW'(psfr_pkg::Q_DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == AW'(psfr_pkg::Q_DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_tok;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(psfr_pkg::Q_DEPTH)) else $error("queue count overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full queue");
`endif

endmodule

FILE: hdl/psfr_back.sv
// Output stage: pops result tokens, forms reported values, holds them in an output register.
// Depends on psfr_pkg for token and status types.
module psfr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  psfr_pkg::t_token i_tok,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [2:0]       o_status,
    output logic [15:0]      o_pm_1_0,
    output logic [15:0]      o_pm_2_5,
    output logic [15:0]      o_pm_10_0
);

    logic        r_valid;
    logic [2:0]  r_status;
    logic [15:0] r_pm_1_0, r_pm_2_5, r_pm_10_0;
    logic        show;

    assign o_pop = i_q_valid && (!r_valid || i_ready);
    assign show  = (i_tok.status == psfr_pkg::ST_RESP_OK) && i_tok.show_pm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status  <= i_tok.status;
            r_pm_1_0  <= show ? i_tok.pm_1_0  : 16'd0;
            r_pm_2_5  <= show ? i_tok.pm_2_5  : 16'd0;
            r_pm_10_0 <= show ? i_tok.pm_10_0 : 16'd0;
        end
    end

    assign o_valid   = r_valid;
    assign o_status  = r_status;
    assign o_pm_1_0  = r_pm_1_0;
    assign o_pm_2_5  = r_pm_2_5;
    assign o_pm_10_0 = r_pm_10_0;

endmodule

FILE: hdl/particle_sensor_frame_receiver_core.sv
// Top level of the particle sensor frame receiver: front end, result queue, output stage.
// Depends on psfr_pkg, psfr_front, psfr_queue and psfr_back.
//
// Takes one UART byte or sent-command transaction per cycle and validates active frames
// (0x42 0x4D, length, 16-bit sum) or, after a 0x86 query is reported sent, 9-byte response
// frames. Each frame result or rejected byte yields one result transaction; other bytes
// yield none. An input transaction is taken every cycle while the two-entry result queue
// has room; the front end's per-transaction position and checksum update sets that rate.
// Results pass through the queue and then an output register.
module particle_sensor_frame_receiver_core #(
    parameter int FRAME_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_gap_expired,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_pm_1_0,
    output logic [15:0] o_pm_2_5,
    output logic [15:0] o_pm_10_0
);

    psfr_pkg::t_token push_tok, pop_tok;
    logic             push, pop, full, q_valid;

    psfr_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_op    (psfr_pkg::t_op'(i_operation)),
        .i_byte  (i_rx_byte),
        .i_gap   (i_gap_expired),
        .i_full  (full),
        .o_push  (push),
        .o_tok   (push_tok)
    );

    psfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (push_tok),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_tok   (pop_tok)
    );

    psfr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_tok     (pop_tok),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_status  (o_status),
        .o_pm_1_0  (o_pm_1_0),
        .o_pm_2_5  (o_pm_2_5),
        .o_pm_10_0 (o_pm_10_0)
    );

endmodule

FILE: tb/sv/frame_result_checker.sv
`timescale 1ns / 100ps
// Checker for the particle sensor frame receiver: watches both channels, keeps its own
// frame receiver model and compares every result transaction. Depends on psfr_pkg.
module frame_result_checker #(
    parameter int FRAME_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_operation,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_gap_expired,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_status,
    input  logic [15:0] i_pm_1_0,
    input  logic [15:0] i_pm_2_5,
    input  logic [15:0] i_pm_10_0,
    output int          o_errors,
    output int          o_pending
);

    localparam int LAST = FRAME_BYTES - 1;

    typedef struct packed {
        psfr_pkg::t_status status;
        logic [15:0]       pm_1_0;
        logic [15:0]       pm_2_5;
        logic [15:0]       pm_10_0;
    } t_reading;

    logic [5:0]  byte_pos;
    logic        resp_mode;
    logic [15:0] csum;
    logic [7:0]  rx_frame [FRAME_BYTES];
    t_reading    expected_readings [$];

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (o_errors < 100)
            $display("%0t ns: %s got %h, want %h", $time, what, got, want);
        o_errors++;
    endtask

    task automatic check_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    function automatic logic [15:0] frame_word(input int idx);
        return {rx_frame[idx], rx_frame[idx + 1]};
    endfunction

    task automatic predict_frame_byte(input psfr_pkg::t_op op, input logic [7:0] value,
                                      input logic gap);
        t_reading rd;
        logic     done;
        logic [5:0] pos;
        rd = '{status: psfr_pkg::ST_HDR_BAD, pm_1_0: '0, pm_2_5: '0, pm_10_0: '0};
        done = 1'b0;
        if (op == psfr_pkg::OP_CMD) begin
            byte_pos = '0;
            csum = '0;
            resp_mode = (value == psfr_pkg::CMD_QUERY);
            return;
        end
        if (gap) begin
            byte_pos = '0;
            csum = '0;
        end
        pos = byte_pos;
        if (pos < FRAME_BYTES)
            rx_frame[pos] = value;
        if (resp_mode) begin
            if (pos == 0) begin
                done = (value != psfr_pkg::HDR_RESPONSE);
            end else if (pos >= psfr_pkg::RESP_LAST) begin
                done = 1'b1;
                if (value != 8'hFF - csum[7:0]) begin
                    rd.status = psfr_pkg::ST_SUM_BAD;
                end else begin
                    resp_mode = 1'b0;
                    rd.status = psfr_pkg::ST_RESP_OK;
                    if (rx_frame[1] == psfr_pkg::CMD_QUERY) begin
                        rd.pm_1_0  = frame_word(6);
                        rd.pm_2_5  = frame_word(2);
                        rd.pm_10_0 = frame_word(4);
                    end
                end
            end
        end else begin
            if ((pos == 0 && value != psfr_pkg::HDR_ACTIVE_0) ||
                (pos == 1 && value != psfr_pkg::HDR_ACTIVE_1)) begin
                done = 1'b1;
            end else if (pos == 3 && {rx_frame[2], value} != 16'(FRAME_BYTES - 4)) begin
                done = 1'b1;
                rd.status = psfr_pkg::ST_LEN_BAD;
            end else if (pos >= LAST) begin
                done = 1'b1;
                rd.status = ({rx_frame[LAST - 1], value} == csum) ?
                            psfr_pkg::ST_ACTIVE_OK : psfr_pkg::ST_SUM_BAD;
            end
        end
        if (done) begin
            byte_pos = '0;
            csum = '0;
            expected_readings.push_back(rd);
        end else begin
            if (pos < LAST - 1)
                csum = csum + value;
            byte_pos = pos + 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_pos = '0;
            csum = '0;
            resp_mode = 1'b0;
            o_errors = 0;
            expected_readings.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch("result with nothing pending, status", 16'(i_status), '0);
                end else begin
                    check_field("status", 16'(i_status), 16'(expected_readings[0].status));
                    check_field("pm_1_0", i_pm_1_0, expected_readings[0].pm_1_0);
                    check_field("pm_2_5", i_pm_2_5, expected_readings[0].pm_2_5);
                    check_field("pm_10_0", i_pm_10_0, expected_readings[0].pm_10_0);
                    void'(expected_readings.pop_front());
                end
            end
            if (i_in_valid && i_in_ready)
                predict_frame_byte(psfr_pkg::t_op'(i_operation), i_rx_byte, i_gap_expired);
        end
        o_pending = expected_readings.size();
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the particle sensor frame receiver: clock, reset, byte stimulus,
// output back-pressure and verdict. Depends on psfr_pkg, the core and frame_result_checker.
module tb_top;

    localparam int FRAME_BYTES  = 32;
    localparam int RANDOM_ITEMS = 500;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_operation;
    logic [7:0]  i_rx_byte;
    logic        i_gap_expired;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic [15:0] o_pm_1_0;
    logic [15:0] o_pm_2_5;
    logic [15:0] o_pm_10_0;

    int         n_errors;
    int         n_pending;
    int         sent;
    bit         steady;
    int         stall_left = 0;
    int         calm_left = 0;
    logic [7:0] frame_bytes [FRAME_BYTES];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    particle_sensor_frame_receiver_core #(
        .FRAME_BYTES(FRAME_BYTES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_operation  (i_operation),
        .i_rx_byte    (i_rx_byte),
        .i_gap_expired(i_gap_expired),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_pm_1_0     (o_pm_1_0),
        .o_pm_2_5     (o_pm_2_5),
        .o_pm_10_0    (o_pm_10_0)
    );

    frame_result_checker #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_operation  (i_operation),
        .i_rx_byte    (i_rx_byte),
        .i_gap_expired(i_gap_expired),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_status     (o_status),
        .i_pm_1_0     (o_pm_1_0),
        .i_pm_2_5     (o_pm_2_5),
        .i_pm_10_0    (o_pm_10_0),
        .o_errors     (n_errors),
        .o_pending    (n_pending)
    );

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic hold_off(input int cycles);
        @(negedge i_clk);
        i_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic send_item(input psfr_pkg::t_op op, input logic [7:0] value,
                             input logic gap);
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_rx_byte     <= value;
        i_gap_expired <= gap;
        do @(posedge i_clk); while (!o_ready);
        sent++;
        if (!steady && $urandom_range(0, 99) < 30)
            hold_off(pick_gap());
    endtask

    task automatic send_frame(input int len, input int bad_at, input logic [7:0] flip,
                              input int gap_at);
        int k;
        for (k = 0; k < len; k++)
            send_item(psfr_pkg::OP_RX, frame_bytes[k] ^ ((k == bad_at) ? flip : 8'h00),
                      (k == gap_at) || (k == 0 && $urandom_range(0, 3) == 0));
    endtask

    task automatic load_response(input logic [7:0] second, input logic [47:0] body);
        logic [7:0] acc;
        int k;
        frame_bytes[0] = psfr_pkg::HDR_RESPONSE;
        frame_bytes[1] = second;
        for (k = 0; k < 6; k++)
            frame_bytes[2 + k] = body[47 - 8 * k -: 8];
        acc = '0;
        for (k = 0; k < psfr_pkg::RESP_LAST; k++)
            acc = acc + frame_bytes[k];
        frame_bytes[psfr_pkg::RESP_LAST] = 8'hFF - acc;
    endtask

    // output back-pressure: short stalls, a few long ones, and calm stretches
    always @(negedge i_clk) begin
        if (stall_left > 0)
            stall_left--;
        else if (calm_left > 0)
            calm_left--;
        else if ($urandom_range(0, 99) < 3)
            calm_left = $urandom_range(40, 160);
        else if ($urandom_range(0, 99) < 25)
            stall_left = pick_gap();
        i_ready <= (stall_left == 0);
    end

    initial begin : watchdog
        int stuck;
        stuck = 0;
        @(posedge i_rst_n);
        while (stuck < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int         kind;
        int         k;
        int         fill;
        int         len;
        int         bad_at;
        int         gap_at;
        logic [15:0] total;
        logic [47:0] body;
        logic [7:0]  second;

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_operation   = 1'b0;
        i_rx_byte     = 8'h00;
        i_gap_expired = 1'b0;
        sent          = 0;
        steady        = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: header, length, response ok with extreme values, response checksum
        send_item(psfr_pkg::OP_RX, 8'h00, 1'b0);
        send_item(psfr_pkg::OP_RX, psfr_pkg::HDR_ACTIVE_0, 1'b0);
        send_item(psfr_pkg::OP_RX, psfr_pkg::HDR_ACTIVE_1, 1'b0);
        send_item(psfr_pkg::OP_RX, 8'h00, 1'b0);
        send_item(psfr_pkg::OP_RX, 8'(FRAME_BYTES - 3), 1'b0);
        send_item(psfr_pkg::OP_CMD, psfr_pkg::CMD_QUERY, 1'b1);
        load_response(psfr_pkg::CMD_QUERY, 48'hFFFF_0000_1234);
        send_frame(psfr_pkg::RESP_LAST + 1, -1, 8'h00, -1);
        send_item(psfr_pkg::OP_CMD, psfr_pkg::CMD_QUERY, 1'b0);
        load_response(psfr_pkg::CMD_QUERY, 48'h0000_FFFF_8001);
        send_frame(psfr_pkg::RESP_LAST + 1, psfr_pkg::RESP_LAST, 8'h01, -1);

        hold_off(1);
        while (n_pending != 0) @(negedge i_clk);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            steady = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 99);
            fill = $urandom_range(0, 9);
            if (kind < 70) begin
                if (kind < 35) begin
                    len = FRAME_BYTES;
                    frame_bytes[0] = psfr_pkg::HDR_ACTIVE_0;
                    frame_bytes[1] = psfr_pkg::HDR_ACTIVE_1;
                    {frame_bytes[2], frame_bytes[3]} = 16'(FRAME_BYTES - 4);
                    for (k = 4; k < FRAME_BYTES - 2; k++)
                        frame_bytes[k] = (fill == 0) ? 8'hFF : (fill == 1) ? 8'h00 : 8'($urandom);
                    total = '0;
                    for (k = 0; k < FRAME_BYTES - 2; k++)
                        total = total + frame_bytes[k];
                    {frame_bytes[FRAME_BYTES - 2], frame_bytes[FRAME_BYTES - 1]} = total;
                end else begin
                    len = psfr_pkg::RESP_LAST + 1;
                    second = ($urandom_range(0, 4) == 0) ? 8'($urandom) : psfr_pkg::CMD_QUERY;
                    body = (fill == 0) ? '1 : (fill == 1) ? '0
                         : {16'($urandom), 32'($urandom)};
                    load_response(second, body);
                    send_item(psfr_pkg::OP_CMD,
                              ($urandom_range(0, 9) == 0) ? 8'($urandom) : psfr_pkg::CMD_QUERY,
                              1'($urandom));
                end
                bad_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len - 1) : -1;
                gap_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : -1;
                send_frame(len, bad_at, 8'($urandom_range(1, 255)), gap_at);
            end else if (kind < 80) begin
                send_item(psfr_pkg::OP_CMD, 8'($urandom), 1'($urandom));
            end else begin
                repeat ($urandom_range(1, 6))
                    send_item(psfr_pkg::OP_RX, 8'($urandom), 1'($urandom));
            end
            if ($urandom_range(0, 19) == 0) begin
                hold_off(1);
                while (n_pending != 0) @(negedge i_clk);
            end
        end

        hold_off(1);
        while (n_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
hdl/psfr_pkg.sv
hdl/psfr_front.sv
hdl/psfr_queue.sv
hdl/psfr_back.sv
hdl/particle_sensor_frame_receiver_core.sv
tb/sv/frame_result_checker.sv
tb/sv/tb_top.sv
